/* hw/rtl/deq_pkg.sv */
// shared types and constants for the double-ended queue
`default_nettype none

package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int ITEM_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;
    localparam logic [2:0] OP_DUMP       = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_BACK,
        CELL_SHIFT_FRONT,
        CELL_LOAD
    } cell_mode_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/deq_cell.sv */
// one storage cell of the deque chain
`default_nettype none

module deq_cell (
    input  wire logic                             clk,
    input  wire deq_pkg::cell_mode_t              mode,
    input  wire logic [deq_pkg::ITEM_WIDTH-1:0]   prev_val,
    input  wire logic [deq_pkg::ITEM_WIDTH-1:0]   next_val,
    input  wire logic [deq_pkg::ITEM_WIDTH-1:0]   load_val,
    output logic      [deq_pkg::ITEM_WIDTH-1:0]   val
);

    logic [deq_pkg::ITEM_WIDTH-1:0] val_reg;
    logic [deq_pkg::ITEM_WIDTH-1:0] val_next;

    always_comb
    begin
        case (mode)
            deq_pkg::CELL_SHIFT_BACK:  val_next = prev_val;
            deq_pkg::CELL_SHIFT_FRONT: val_next = next_val;
            deq_pkg::CELL_LOAD:        val_next = load_val;
            default:                   val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

`default_nettype wire

/* hw/rtl/double_ended_queue.sv */
// Bounded double-ended queue built as a row of storage cells.
//
// Input channel (in_valid/in_ready) carries op, item_in and index; output
// channel (out_valid/out_ready) carries item_out, status, count, is_empty and
// last. The front entry always sits in cell 0: a push at the front shifts the
// row toward the back, a pop at the front shifts it toward the front, a push
// at the back loads the cell at the current count.
// Push, pop and read give one item in the cycle after acceptance, and a new
// item is taken every cycle as long as the output register is free or being
// drained. A dump rotates the whole row once, one cell per cycle while the
// receiver takes results, emitting cell 0 while the step is below the count;
// no input is taken until the rotation is back at its start. Op codes 6 and
// 7 are taken and give no item.
// Reset empties the deque and drops any pending result; the cell contents
// are not cleared. When the receiver stalls, the result holds in the output
// register and the input side and any dump in progress wait for it.
`default_nettype none

module double_ended_queue (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [2:0]                        op,
    input  wire logic [deq_pkg::ITEM_WIDTH-1:0]    item_in,
    input  wire logic [deq_pkg::IDX_W-1:0]         index,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [deq_pkg::ITEM_WIDTH-1:0]    item_out,
    output logic      [1:0]                        status,
    output logic      [deq_pkg::CNT_W-1:0]         count,
    output logic                                   is_empty,
    output logic                                   last
);

    localparam int DEPTH = deq_pkg::DEPTH;
    localparam int IW    = deq_pkg::ITEM_WIDTH;
    localparam int IDX_W = deq_pkg::IDX_W;
    localparam int CNT_W = deq_pkg::CNT_W;

    deq_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic             out_valid_reg, out_valid_next;
    logic [IW-1:0]    item_out_reg, item_out_next;
    logic [1:0]       status_reg, status_next;
    logic             last_reg, last_next;

    deq_pkg::cell_mode_t mode [DEPTH];
    logic [IW-1:0]       cell_val [DEPTH];

    logic             slot_free;
    logic             accept;
    logic             res_load;
    logic [IDX_W-1:0] rd_addr;
    logic [IW-1:0]    rd_val;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            deq_cell u_cell (
                .clk      (clk),
                .mode     (mode[gi]),
                .prev_val ((gi == 0) ? item_in : cell_val[(gi + DEPTH - 1) % DEPTH]),
                .next_val (cell_val[(gi + 1) % DEPTH]),
                .load_val (item_in),
                .val      (cell_val[gi])
            );
        end
    endgenerate

    // single read port: back entry for pop back, indexed entry for read
    assign rd_addr = (op == deq_pkg::OP_POP_BACK) ? IDX_W'(count_reg - CNT_W'(1)) : index;
    assign rd_val  = cell_val[rd_addr];

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == deq_pkg::S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        res_load      = 1'b0;
        item_out_next = item_out_reg;
        status_next   = status_reg;
        last_next     = last_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            mode[i] = deq_pkg::CELL_HOLD;
        end

        unique case (state_reg)
            deq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_out_next = '0;
                    status_next   = deq_pkg::STATUS_OK;
                    last_next     = 1'b1;
                    case (op)
                        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK:
                        begin
                            res_load = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = deq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                if (op == deq_pkg::OP_PUSH_FRONT)
                                begin
                                    for (int i = 0; i < DEPTH; i++)
                                    begin
                                        mode[i] = deq_pkg::CELL_SHIFT_BACK;
                                    end
                                end
                                else
                                begin
                                    mode[count_reg[IDX_W-1:0]] = deq_pkg::CELL_LOAD;
                                end
                            end
                        end
                        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:
                        begin
                            res_load = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                if (op == deq_pkg::OP_POP_FRONT)
                                begin
                                    item_out_next = cell_val[0];
                                    for (int i = 0; i < DEPTH; i++)
                                    begin
                                        mode[i] = deq_pkg::CELL_SHIFT_FRONT;
                                    end
                                end
                                else
                                begin
                                    item_out_next = rd_val;
                                end
                            end
                        end
                        deq_pkg::OP_READ:
                        begin
                            res_load = 1'b1;
                            if (CNT_W'(index) >= count_reg)
                            begin
                                status_next = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                item_out_next = rd_val;
                            end
                        end
                        deq_pkg::OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load    = 1'b1;
                                status_next = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                state_next = deq_pkg::S_DUMP;
                                step_next  = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            deq_pkg::S_DUMP:
            begin
                if (slot_free)
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        mode[i] = deq_pkg::CELL_SHIFT_FRONT;
                    end
                    step_next = step_reg + IDX_W'(1);
                    // rotation continues past the count to restore the order
                    if (CNT_W'(step_reg) < count_reg)
                    begin
                        res_load      = 1'b1;
                        item_out_next = cell_val[0];
                        status_next   = deq_pkg::STATUS_OK;
                        last_next     = (CNT_W'(step_reg) + CNT_W'(1)) == count_reg;
                    end
                    if (step_reg == IDX_W'(DEPTH - 1))
                    begin
                        state_next = deq_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !out_ready) || res_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= deq_pkg::S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            item_out_reg <= item_out_next;
            status_reg   <= status_next;
            last_reg     <= last_next;
        end
    end

    logic [CNT_W-1:0] res_count_reg;

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_count_reg <= count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign item_out  = item_out_reg;
    assign status    = status_reg;
    assign count     = res_count_reg;
    assign is_empty  = (res_count_reg == '0);
    assign last      = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/deq_checker.sv */
// port-level checks for the double-ended queue, bound to the top level
`default_nettype none

module deq_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [deq_pkg::ITEM_WIDTH-1:0]    item_out,
    input wire logic [1:0]                        status,
    input wire logic [deq_pkg::CNT_W-1:0]         count,
    input wire logic                              is_empty,
    input wire logic                              last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_out) && $stable(last))
        else $error("output item changed while stalled");

    // failed operations carry no item and end their sequence
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != deq_pkg::STATUS_OK) |-> (item_out == '0) && last)
        else $error("failed operation with item or without last");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> is_empty == (count == '0))
        else $error("is_empty disagrees with count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == deq_pkg::STATUS_FULL) |-> count == deq_pkg::CNT_W'(deq_pkg::DEPTH))
        else $error("full status below capacity");

    // within a dump the count stays the same from one item to the next
    a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last ##1 out_valid |-> $stable(count))
        else $error("count changed within a dump");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .item_out  (item_out),
    .status    (status),
    .count     (count),
    .is_empty  (is_empty),
    .last      (last)
);

`default_nettype wire

/* tb/tb_double_ended_queue.sv */
`timescale 1ns / 1ps
// testbench for the double-ended queue: directed and random traffic checked against a shadow deque

module tb_double_ended_queue;

    localparam int QUIET_LIMIT = 2000;

    // op codes the block takes and drops without a result
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [deq_pkg::ITEM_WIDTH-1:0] item;
        logic [1:0]                     status;
        logic [deq_pkg::CNT_W-1:0]      count;
        logic                           is_empty;
        logic                           last;
    } deque_reply_t;

    class deque_scoreboard;
        logic [deq_pkg::ITEM_WIDTH-1:0] shadow_store [deq_pkg::DEPTH];
        int                             shadow_head = 0;
        int                             shadow_fill = 0;
        deque_reply_t                   awaited_replies [$];
        int                             mismatches = 0;

        function void owe(logic [deq_pkg::ITEM_WIDTH-1:0] value, logic [1:0] code,
                          logic is_last);
            deque_reply_t r;
            r.item     = value;
            r.status   = code;
            r.count    = deq_pkg::CNT_W'(shadow_fill);
            r.is_empty = (shadow_fill == 0);
            r.last     = is_last;
            awaited_replies.push_back(r);
        endfunction

        function void take_request(logic [2:0] code, logic [deq_pkg::ITEM_WIDTH-1:0] value,
                                   logic [deq_pkg::IDX_W-1:0] pos);
            logic [deq_pkg::ITEM_WIDTH-1:0] v;
            case (code)
                deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK:
                begin
                    if (shadow_fill == deq_pkg::DEPTH)
                        owe('0, deq_pkg::STATUS_FULL, 1'b1);
                    else
                    begin
                        if (code == deq_pkg::OP_PUSH_FRONT)
                        begin
                            shadow_head = (shadow_head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
                            shadow_store[shadow_head] = value;
                        end
                        else
                            shadow_store[(shadow_head + shadow_fill) % deq_pkg::DEPTH] = value;
                        shadow_fill++;
                        owe('0, deq_pkg::STATUS_OK, 1'b1);
                    end
                end
                deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK:
                begin
                    if (shadow_fill == 0)
                        owe('0, deq_pkg::STATUS_EMPTY, 1'b1);
                    else
                    begin
                        if (code == deq_pkg::OP_POP_FRONT)
                        begin
                            v = shadow_store[shadow_head];
                            shadow_head = (shadow_head + 1) % deq_pkg::DEPTH;
                        end
                        else
                            v = shadow_store[(shadow_head + shadow_fill - 1) % deq_pkg::DEPTH];
                        shadow_fill--;
                        owe(v, deq_pkg::STATUS_OK, 1'b1);
                    end
                end
                deq_pkg::OP_READ:
                begin
                    if (int'(pos) >= shadow_fill)
                        owe('0, deq_pkg::STATUS_EMPTY, 1'b1);
                    else
                        owe(shadow_store[(shadow_head + int'(pos)) % deq_pkg::DEPTH],
                            deq_pkg::STATUS_OK, 1'b1);
                end
                deq_pkg::OP_DUMP:
                begin
                    if (shadow_fill == 0)
                        owe('0, deq_pkg::STATUS_EMPTY, 1'b1);
                    else
                        for (int i = 0; i < shadow_fill; i++)
                            owe(shadow_store[(shadow_head + i) % deq_pkg::DEPTH],
                                deq_pkg::STATUS_OK, i == shadow_fill - 1);
                end
                default:
                    ;
            endcase
        endfunction

        task report_mismatch(string what, logic [deq_pkg::ITEM_WIDTH-1:0] got,
                             logic [deq_pkg::ITEM_WIDTH-1:0] want);
            $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_reply(deque_reply_t got);
            deque_reply_t want;
            if (awaited_replies.size() == 0)
            begin
                report_mismatch("item with nothing pending, item_out", got.item, '0);
                return;
            end
            want = awaited_replies.pop_front();
            if (got.item !== want.item)
                report_mismatch("item_out", got.item, want.item);
            if (got.status !== want.status)
                report_mismatch("status", deq_pkg::ITEM_WIDTH'(got.status),
                                deq_pkg::ITEM_WIDTH'(want.status));
            if (got.count !== want.count)
                report_mismatch("count", deq_pkg::ITEM_WIDTH'(got.count),
                                deq_pkg::ITEM_WIDTH'(want.count));
            if (got.is_empty !== want.is_empty)
                report_mismatch("is_empty", deq_pkg::ITEM_WIDTH'(got.is_empty),
                                deq_pkg::ITEM_WIDTH'(want.is_empty));
            if (got.last !== want.last)
                report_mismatch("last", deq_pkg::ITEM_WIDTH'(got.last),
                                deq_pkg::ITEM_WIDTH'(want.last));
        endtask
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [2:0]                     op = deq_pkg::OP_PUSH_FRONT;
    logic [deq_pkg::ITEM_WIDTH-1:0] item_in = '0;
    logic [deq_pkg::IDX_W-1:0]      index = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [deq_pkg::ITEM_WIDTH-1:0] item_out;
    logic [1:0]                     status;
    logic [deq_pkg::CNT_W-1:0]      count;
    logic                           is_empty;
    logic                           last;

    deque_scoreboard sb = new();
    int              send_idle_pct = 0;
    int              stall_pct = 0;
    int              quiet_cycles = 0;
    bit              filling_up = 1'b1;

    double_ended_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .item_in   (item_in),
        .index     (index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .item_out  (item_out),
        .status    (status),
        .count     (count),
        .is_empty  (is_empty),
        .last      (last)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // watch both channels; also ends the run if nothing moves for too long
    always @(posedge clk)
    begin
        deque_reply_t got;
        if (!rst_n)
            quiet_cycles = 0;
        else
        begin
            if (in_valid && in_ready)
                sb.take_request(op, item_in, index);
            if (out_valid && out_ready)
            begin
                got.item     = item_out;
                got.status   = status;
                got.count    = count;
                got.is_empty = is_empty;
                got.last     = last;
                sb.check_reply(got);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_double_ended_queue failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [2:0] code,
                             input logic [deq_pkg::ITEM_WIDTH-1:0] value,
                             input logic [deq_pkg::IDX_W-1:0] pos);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        item_in  <= value;
        index    <= pos;
        // ready is sampled mid-cycle, the item goes at the following edge
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // bias toward filling until full, then toward draining until empty
    task automatic run_random_phase(input int n);
        int                             r;
        logic [deq_pkg::ITEM_WIDTH-1:0] word;
        logic [deq_pkg::IDX_W-1:0]      pos;
        repeat (n)
        begin
            if (filling_up && sb.shadow_fill == deq_pkg::DEPTH && $urandom_range(0, 2) == 0)
                filling_up = 1'b0;
            else if (!filling_up && sb.shadow_fill == 0 && $urandom_range(0, 2) == 0)
                filling_up = 1'b1;
            case ($urandom_range(0, 9))
                0:       word = '0;
                1:       word = '1;
                default: word = $urandom;
            endcase
            pos = deq_pkg::IDX_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < (filling_up ? 78 : 10))
                send_item($urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT,
                          word, pos);
            else if (r < (filling_up ? 84 : 70))
                send_item($urandom_range(0, 1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT,
                          word, pos);
            else if (r < 92)
            begin
                if (sb.shadow_fill > 0 && $urandom_range(0, 1))
                    pos = deq_pkg::IDX_W'($urandom_range(0, sb.shadow_fill - 1));
                send_item(deq_pkg::OP_READ, word, pos);
            end
            else if (r < 96)
                send_item(deq_pkg::OP_DUMP, word, pos);
            else
                send_item($urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO, word, pos);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty deque, dropped codes, wrap of the front, reads past the end
        send_item(deq_pkg::OP_POP_FRONT, '0, '0);
        send_item(deq_pkg::OP_POP_BACK, '1, '1);
        send_item(deq_pkg::OP_READ, '0, '0);
        send_item(deq_pkg::OP_DUMP, '0, '0);
        send_item(OP_SPARE_LO, '0, '0);
        send_item(OP_SPARE_HI, '1, '1);
        send_item(deq_pkg::OP_PUSH_BACK, '1, '0);
        send_item(deq_pkg::OP_PUSH_FRONT, '0, '1);
        send_item(deq_pkg::OP_PUSH_BACK, 32'ha5a5_5a5a, '0);
        send_item(deq_pkg::OP_READ, '0, 4'd0);
        send_item(deq_pkg::OP_READ, '0, 4'd2);
        send_item(deq_pkg::OP_READ, '0, 4'd3);
        send_item(deq_pkg::OP_READ, '0, '1);
        send_item(deq_pkg::OP_DUMP, '0, '0);
        send_item(deq_pkg::OP_POP_BACK, '0, '0);
        send_item(deq_pkg::OP_POP_FRONT, '0, '0);
        send_item(deq_pkg::OP_POP_FRONT, '0, '0);
        send_item(deq_pkg::OP_POP_FRONT, '0, '0);

        run_random_phase(20);
        send_idle_pct = 62;
        run_random_phase(20);
        send_idle_pct = 0;
        stall_pct = 62;
        run_random_phase(20);
        send_idle_pct = 22;
        stall_pct = 22;
        run_random_phase(20);

        in_valid <= 1'b0;
        while (sb.awaited_replies.size() != 0)
            @(posedge clk);
        repeat (deq_pkg::DEPTH + 4) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb_double_ended_queue passed");
        else
            $display("tb_double_ended_queue failed");
        $finish;
    end

endmodule
